// ===== hw/rtl/usc_pkg.sv =====
// ----------------------------------------------------------------------------
// usc_pkg
// Shared widths, conversion constants and types for the Unix seconds to
// calendar date pipeline.
// ----------------------------------------------------------------------------
package usc_pkg;

	// Pipeline depth
	localparam int unsigned NSTAGE = 11;

	// Field widths
	localparam int unsigned SECS_W  = 32;
	localparam int unsigned YEAR_W  = 12;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned DAY_W   = 5;
	localparam int unsigned HOUR_W  = 5;
	localparam int unsigned MIN_W   = 6;
	localparam int unsigned SEC_W   = 6;

	// Intermediate widths
	localparam int unsigned Q1_W   = 27;  // seconds / 60
	localparam int unsigned Q2_W   = 21;  // minutes / 60
	localparam int unsigned DAYS_W = 16;  // hours / 24
	localparam int unsigned XA_W   = 19;
	localparam int unsigned A_W    = 5;
	localparam int unsigned B_W    = 22;
	localparam int unsigned X_W    = 26;
	localparam int unsigned C_W    = 13;
	localparam int unsigned D_W    = 10;
	localparam int unsigned E_W    = 6;
	localparam int unsigned G_W    = 6;

	// Reciprocals: M = ceil(2^K / divisor), K = input width + clog2(divisor),
	// which makes floor(x * M / 2^K) exact over the whole input range.
	localparam int unsigned K60A   = SECS_W + 6;
	localparam int unsigned M60A_W = 33;
	localparam logic [M60A_W-1:0] M60A =
		M60A_W'(((64'd1 << K60A) + 64'd59) / 64'd60);

	localparam int unsigned K60B   = Q1_W + 6;
	localparam int unsigned M60B_W = 28;
	localparam logic [M60B_W-1:0] M60B =
		M60B_W'(((64'd1 << K60B) + 64'd59) / 64'd60);

	localparam int unsigned K24   = Q2_W + 5;
	localparam int unsigned M24_W = 22;
	localparam logic [M24_W-1:0] M24 =
		M24_W'(((64'd1 << K24) + 64'd23) / 64'd24);

	localparam int unsigned K7305   = X_W + 13;
	localparam int unsigned M7305_W = 27;
	localparam logic [M7305_W-1:0] M7305 =
		M7305_W'(((64'd1 << K7305) + 64'd7304) / 64'd7305);

	// d * 1000 / 30601, the factor 1000 folded into the reciprocal
	localparam int unsigned KE   = D_W + 10 + 15;
	localparam int unsigned ME_W = 31;
	localparam logic [ME_W-1:0] ME =
		ME_W'(64'd1000 * (((64'd1 << KE) + 64'd30600) / 64'd30601));

	// e * 601 / 1000, the factor 601 folded into the reciprocal
	localparam int unsigned KF   = 16 + 10;
	localparam int unsigned MF_W = 26;
	localparam logic [MF_W-1:0] MF =
		MF_W'(64'd601 * (((64'd1 << KF) + 64'd999) / 64'd1000));

	// Day-number chain constants
	localparam int unsigned A_OFS          = 102032;
	localparam int unsigned A_CYC          = 146097;
	localparam int unsigned A_BASE         = 15;
	localparam int unsigned B_OFS          = 2442113;
	localparam int unsigned C_OFS          = 2442;
	localparam int unsigned DAYS_YR        = 365;
	localparam int unsigned MONTH_DAYS     = 30;
	localparam int unsigned E_SPLIT        = 13;
	localparam int unsigned YEAR_ADJ_EARLY = 4716;
	localparam int unsigned YEAR_ADJ_LATE  = 4715;
	localparam int unsigned MON_ADJ_EARLY  = 1;
	localparam int unsigned MON_ADJ_LATE   = 13;

	typedef struct packed {
		logic [NSTAGE-1:0] en;
	} pipe_ctrl_t;

	typedef struct packed {
		logic              ok;
		logic [HOUR_W-1:0] hour;
		logic [MIN_W-1:0]  minute;
		logic [SEC_W-1:0]  second;
	} tod_t;

	typedef struct packed {
		logic               ok;
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic [HOUR_W-1:0]  hour;
		logic [MIN_W-1:0]   minute;
		logic [SEC_W-1:0]   second;
	} cal_t;

endpackage

// ===== hw/rtl/usc_in_if.sv =====
// ----------------------------------------------------------------------------
// usc_in_if
// Valid/ready channel carrying one Unix seconds count per transfer.
// ----------------------------------------------------------------------------
interface usc_in_if;
	logic                        valid;
	logic                        ready;
	logic [usc_pkg::SECS_W-1:0]  unix_seconds;

	modport source (output valid, output unix_seconds, input ready);
	modport sink   (input valid, input unix_seconds, output ready);
endinterface

// ===== hw/rtl/usc_out_if.sv =====
// ----------------------------------------------------------------------------
// usc_out_if
// Valid/ready channel carrying one calendar date and time per transfer.
// ----------------------------------------------------------------------------
interface usc_out_if;
	logic                         valid;
	logic                         ready;
	logic                         ok;
	logic [usc_pkg::YEAR_W-1:0]   year;
	logic [usc_pkg::MONTH_W-1:0]  month;
	logic [usc_pkg::DAY_W-1:0]    day;
	logic [usc_pkg::HOUR_W-1:0]   hour;
	logic [usc_pkg::MIN_W-1:0]    minute;
	logic [usc_pkg::SEC_W-1:0]    second;

	modport source (output valid, output ok, output year, output month, output day,
		output hour, output minute, output second, input ready);
	modport sink   (input valid, input ok, input year, input month, input day,
		input hour, input minute, input second, output ready);
endinterface

// ===== hw/rtl/usc_pipe_ctrl.sv =====
// ----------------------------------------------------------------------------
// usc_pipe_ctrl
// Valid bits and per-stage load enables; a stage loads when it is empty or
// the stage after it loads, so bubbles close up under a stall.
// ----------------------------------------------------------------------------
module usc_pipe_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output usc_pkg::pipe_ctrl_t  ctrl
);

	logic [usc_pkg::NSTAGE-1:0] vld_q;
	logic [usc_pkg::NSTAGE-1:0] en;

	always_comb begin
		en[usc_pkg::NSTAGE-1] = !vld_q[usc_pkg::NSTAGE-1] || out_ready;
		for (int i = usc_pkg::NSTAGE - 2; i >= 0; i--) begin
			en[i] = !vld_q[i] || en[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int i = 1; i < usc_pkg::NSTAGE; i++) begin
				if (en[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	assign ctrl.en    = en;
	assign in_ready   = en[0];
	assign out_valid  = vld_q[usc_pkg::NSTAGE-1];

endmodule

// ===== hw/rtl/usc_tod.sv =====
// ----------------------------------------------------------------------------
// usc_tod
// Stages 1 to 4: split seconds, minutes and hours off the count by
// reciprocal multiplication, leaving the whole day count.
// ----------------------------------------------------------------------------
module usc_tod (
	input  logic                        clk,
	input  usc_pkg::pipe_ctrl_t         ctrl,
	input  logic [usc_pkg::SECS_W-1:0]  unix_seconds,
	output logic [usc_pkg::DAYS_W-1:0]  days,
	output usc_pkg::tod_t               tod
);

	localparam int unsigned P1_W = usc_pkg::SECS_W + usc_pkg::M60A_W;
	localparam int unsigned P2_W = usc_pkg::Q1_W + usc_pkg::M60B_W;
	localparam int unsigned P3_W = usc_pkg::Q2_W + usc_pkg::M24_W;

	// stage 1
	logic [P1_W-1:0]             p1;
	logic [usc_pkg::Q1_W-1:0]    q1_s1;
	logic [usc_pkg::SEC_W-1:0]   t6_s1;
	logic                        ok_s1;
	// stage 2
	logic [P2_W-1:0]             p2;
	logic [usc_pkg::SEC_W-1:0]   r1;
	logic [usc_pkg::Q2_W-1:0]    q2_s2;
	logic [usc_pkg::MIN_W-1:0]   q1lo_s2;
	logic [usc_pkg::SEC_W-1:0]   sec_s2;
	logic                        ok_s2;
	// stage 3
	logic [P3_W-1:0]             p3;
	logic [usc_pkg::MIN_W-1:0]   r2;
	logic [usc_pkg::DAYS_W-1:0]  days_s3;
	logic [usc_pkg::HOUR_W-1:0]  q2lo_s3;
	logic [usc_pkg::MIN_W-1:0]   min_s3;
	logic [usc_pkg::SEC_W-1:0]   sec_s3;
	logic                        ok_s3;
	// stage 4
	logic [usc_pkg::HOUR_W-1:0]  r3;
	logic [usc_pkg::DAYS_W-1:0]  days_s4;
	usc_pkg::tod_t               tod_s4;

	assign p1 = P1_W'(unix_seconds) * P1_W'(usc_pkg::M60A);
	assign p2 = P2_W'(q1_s1) * P2_W'(usc_pkg::M60B);
	assign p3 = P3_W'(q2_s2) * P3_W'(usc_pkg::M24);

	// remainders need only the low bits of x - 60q (x - 24q for the hours)
	assign r1 = usc_pkg::SEC_W'(q1_s1[usc_pkg::SEC_W-1:0] * usc_pkg::SEC_W'(60));
	assign r2 = usc_pkg::MIN_W'(q2_s2[usc_pkg::MIN_W-1:0] * usc_pkg::MIN_W'(60));
	assign r3 = usc_pkg::HOUR_W'(days_s3[usc_pkg::HOUR_W-1:0] * usc_pkg::HOUR_W'(24));

	always_ff @(posedge clk) begin
		if (ctrl.en[0]) begin
			q1_s1 <= p1[usc_pkg::K60A+usc_pkg::Q1_W-1:usc_pkg::K60A];
			t6_s1 <= unix_seconds[usc_pkg::SEC_W-1:0];
			ok_s1 <= (unix_seconds != '0);
		end
		if (ctrl.en[1]) begin
			q2_s2   <= p2[usc_pkg::K60B+usc_pkg::Q2_W-1:usc_pkg::K60B];
			q1lo_s2 <= q1_s1[usc_pkg::MIN_W-1:0];
			sec_s2  <= t6_s1 - r1;
			ok_s2   <= ok_s1;
		end
		if (ctrl.en[2]) begin
			days_s3 <= p3[usc_pkg::K24+usc_pkg::DAYS_W-1:usc_pkg::K24];
			q2lo_s3 <= q2_s2[usc_pkg::HOUR_W-1:0];
			min_s3  <= q1lo_s2 - r2;
			sec_s3  <= sec_s2;
			ok_s3   <= ok_s2;
		end
		if (ctrl.en[3]) begin
			days_s4       <= days_s3;
			tod_s4.hour   <= q2lo_s3 - r3;
			tod_s4.minute <= min_s3;
			tod_s4.second <= sec_s3;
			tod_s4.ok     <= ok_s3;
		end
	end

	assign days = days_s4;
	assign tod  = tod_s4;

endmodule

// ===== hw/rtl/usc_date.sv =====
// ----------------------------------------------------------------------------
// usc_date
// Stages 5 to 11: day count to year, month and day via the Julian-day chain;
// the last stage is the output register.
// ----------------------------------------------------------------------------
module usc_date (
	input  logic                        clk,
	input  usc_pkg::pipe_ctrl_t         ctrl,
	input  logic [usc_pkg::DAYS_W-1:0]  days,
	input  usc_pkg::tod_t               tod,
	output usc_pkg::cal_t               result
);

	localparam int unsigned P8_W  = usc_pkg::X_W + usc_pkg::M7305_W;
	localparam int unsigned P10_W = usc_pkg::D_W + usc_pkg::ME_W;
	localparam int unsigned PF_W  = usc_pkg::E_W + usc_pkg::MF_W;
	localparam logic [usc_pkg::XA_W-1:0] A_CYC1 = usc_pkg::XA_W'(usc_pkg::A_CYC);
	localparam logic [usc_pkg::XA_W-1:0] A_CYC2 = usc_pkg::XA_W'(2 * usc_pkg::A_CYC);

	logic [usc_pkg::XA_W-1:0]   xa;
	logic [1:0]                 a0;
	logic [usc_pkg::A_W-1:0]    a_s5;
	logic [usc_pkg::DAYS_W-1:0] days_s5;
	logic [usc_pkg::B_W-1:0]    b_s6, b_s7, b_s8;
	logic [usc_pkg::X_W:0]      x_full;
	logic [usc_pkg::X_W-1:0]    x_s7;
	logic [P8_W-1:0]            p8;
	logic [usc_pkg::C_W-1:0]    c_s8, c_s9, c_s10;
	logic [usc_pkg::B_W-1:0]    d_full;
	logic [usc_pkg::D_W-1:0]    d_s9, d_s10;
	logic [P10_W-1:0]           p10;
	logic [usc_pkg::E_W-1:0]    e_s10;
	logic [PF_W-1:0]            pf;
	logic [usc_pkg::D_W-1:0]    f_full;
	logic [usc_pkg::C_W-1:0]    year_full;
	logic [usc_pkg::E_W-1:0]    month_full;
	logic                       early;
	usc_pkg::tod_t              tod_s5, tod_s6, tod_s7, tod_s8, tod_s9, tod_s10;
	usc_pkg::cal_t              res_s11;

	// a = (4 * days + 102032) / 146097 + 15; the quotient is 0, 1 or 2
	always_comb begin
		xa = usc_pkg::XA_W'({days, 2'b00}) + usc_pkg::XA_W'(usc_pkg::A_OFS);
		if (xa >= A_CYC2) begin
			a0 = 2'd2;
		end else if (xa >= A_CYC1) begin
			a0 = 2'd1;
		end else begin
			a0 = 2'd0;
		end
	end

	// 20 * b - 2442 as shift-add
	assign x_full = (usc_pkg::X_W+1)'({b_s6, 4'b0000})
		+ (usc_pkg::X_W+1)'({b_s6, 2'b00})
		- (usc_pkg::X_W+1)'(usc_pkg::C_OFS);

	assign p8 = P8_W'(x_s7) * P8_W'(usc_pkg::M7305);

	// d is small and non-negative, so modular arithmetic is exact
	assign d_full = b_s8
		- usc_pkg::B_W'(usc_pkg::B_W'(c_s8) * usc_pkg::B_W'(usc_pkg::DAYS_YR))
		- usc_pkg::B_W'(c_s8 >> 2);

	assign p10 = P10_W'(d_s9) * P10_W'(usc_pkg::ME);
	assign pf  = PF_W'(e_s10) * PF_W'(usc_pkg::MF);

	assign f_full = d_s10
		- usc_pkg::D_W'(usc_pkg::D_W'(e_s10) * usc_pkg::D_W'(usc_pkg::MONTH_DAYS))
		- usc_pkg::D_W'(pf[usc_pkg::KF+usc_pkg::G_W-1:usc_pkg::KF]);

	// months 14 and 15 of the chain are January and February of the next year
	assign early      = (e_s10 <= usc_pkg::E_W'(usc_pkg::E_SPLIT));
	assign year_full  = early ? c_s10 - usc_pkg::C_W'(usc_pkg::YEAR_ADJ_EARLY)
	                          : c_s10 - usc_pkg::C_W'(usc_pkg::YEAR_ADJ_LATE);
	assign month_full = early ? e_s10 - usc_pkg::E_W'(usc_pkg::MON_ADJ_EARLY)
	                          : e_s10 - usc_pkg::E_W'(usc_pkg::MON_ADJ_LATE);

	always_ff @(posedge clk) begin
		if (ctrl.en[4]) begin
			days_s5 <= days;
			a_s5    <= usc_pkg::A_W'(usc_pkg::A_BASE) + usc_pkg::A_W'(a0);
			tod_s5  <= tod;
		end
		if (ctrl.en[5]) begin
			b_s6 <= usc_pkg::B_W'(days_s5) + usc_pkg::B_W'(usc_pkg::B_OFS)
				+ usc_pkg::B_W'(a_s5) - usc_pkg::B_W'(a_s5 >> 2);
			tod_s6 <= tod_s5;
		end
		if (ctrl.en[6]) begin
			x_s7   <= x_full[usc_pkg::X_W-1:0];
			b_s7   <= b_s6;
			tod_s7 <= tod_s6;
		end
		if (ctrl.en[7]) begin
			c_s8   <= p8[usc_pkg::K7305+usc_pkg::C_W-1:usc_pkg::K7305];
			b_s8   <= b_s7;
			tod_s8 <= tod_s7;
		end
		if (ctrl.en[8]) begin
			d_s9   <= d_full[usc_pkg::D_W-1:0];
			c_s9   <= c_s8;
			tod_s9 <= tod_s8;
		end
		if (ctrl.en[9]) begin
			e_s10   <= p10[usc_pkg::KE+usc_pkg::E_W-1:usc_pkg::KE];
			d_s10   <= d_s9;
			c_s10   <= c_s9;
			tod_s10 <= tod_s9;
		end
		if (ctrl.en[10]) begin
			res_s11.ok     <= tod_s10.ok;
			res_s11.hour   <= tod_s10.hour;
			res_s11.minute <= tod_s10.minute;
			res_s11.second <= tod_s10.second;
			if (tod_s10.ok) begin
				res_s11.year  <= year_full[usc_pkg::YEAR_W-1:0];
				res_s11.month <= month_full[usc_pkg::MONTH_W-1:0];
				res_s11.day   <= f_full[usc_pkg::DAY_W-1:0];
			end else begin
				res_s11.year  <= '0;
				res_s11.month <= '0;
				res_s11.day   <= '0;
			end
		end
	end

	assign result = res_s11;

endmodule

// ===== hw/rtl/unix_seconds_to_calendar_date.sv =====
// ----------------------------------------------------------------------------
// unix_seconds_to_calendar_date
// Converts a 32-bit Unix seconds count into Gregorian date and time of day.
// ----------------------------------------------------------------------------
// Each transfer on stamp carries one count of seconds since 1970-01-01
// 00:00:00; its result leaves the output register of stage 11 on calendar.
// Throughput is one transfer per cycle while calendar takes results: the
// conversion is an eleven-stage pipeline with one constant multiplication or
// one short add/compare chain per stage, and every stage can hold a new item.
// A stall on calendar holds the full stages behind it while empty stages close
// up, so stamp only drops ready when all eleven stages are full and the result
// is not taken. A count of zero is reported with ok low and every field zero;
// all other counts give 1970-01-01 00:00:01 up to 2106-02-07 06:28:15.
//
// Stages:
//   1-3   divide by 60, 60 and 24 via exact reciprocal multiplication
//   4     hour remainder; day count ready
//   5-10  Julian-day chain: century term, day number, year, day of year,
//         chain month
//   11    day of month, Jan/Feb fold-back, zero handling; output register
// ----------------------------------------------------------------------------
module unix_seconds_to_calendar_date (
	input  logic             clk,
	input  logic             arst_n,
	usc_in_if.sink           stamp,
	usc_out_if.source        calendar
);

	usc_pkg::pipe_ctrl_t         ctrl;
	logic [usc_pkg::DAYS_W-1:0]  days;
	usc_pkg::tod_t               tod;
	usc_pkg::cal_t               result;

	// valid bits and load enables
	usc_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (stamp.valid),
		.in_ready  (stamp.ready),
		.out_valid (calendar.valid),
		.out_ready (calendar.ready),
		.ctrl      (ctrl)
	);

	// seconds, minutes, hours and day count
	usc_tod u_tod (
		.clk          (clk),
		.ctrl         (ctrl),
		.unix_seconds (stamp.unix_seconds),
		.days         (days),
		.tod          (tod)
	);

	// day count to year, month, day
	usc_date u_date (
		.clk    (clk),
		.ctrl   (ctrl),
		.days   (days),
		.tod    (tod),
		.result (result)
	);

	assign calendar.ok     = result.ok;
	assign calendar.year   = result.year;
	assign calendar.month  = result.month;
	assign calendar.day    = result.day;
	assign calendar.hour   = result.hour;
	assign calendar.minute = result.minute;
	assign calendar.second = result.second;

`ifndef SYNTHESIS
	// input is only refused while the full pipeline waits on the output
	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!stamp.ready |-> (calendar.valid && !calendar.ready))
		else $error("stamp not ready without an output stall");

	// a rejected zero count carries an all-zero result
	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		(calendar.valid && !calendar.ok) |-> (calendar.year == '0 && calendar.month == '0
		&& calendar.day == '0 && calendar.hour == '0 && calendar.minute == '0
		&& calendar.second == '0))
		else $error("rejected input with non-zero fields");

	// converted dates lie in the representable span
	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		(calendar.valid && calendar.ok) |-> (calendar.year >= 12'd1970
		&& calendar.year <= 12'd2106 && calendar.month >= 4'd1 && calendar.month <= 4'd12
		&& calendar.day >= 5'd1 && calendar.day <= 5'd31))
		else $error("date field out of range");

	// time-of-day remainders stay below their divisors
	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		calendar.valid |-> (calendar.hour <= 5'd23 && calendar.minute <= 6'd59
		&& calendar.second <= 6'd59))
		else $error("time field out of range");
`endif

endmodule

// ===== tb/tb_unix_seconds_to_calendar_date.sv =====
// ----------------------------------------------------------------------------
// tb_unix_seconds_to_calendar_date
// Self-checking bench for the Unix seconds to calendar date pipeline.
// ----------------------------------------------------------------------------
// Seconds counts go in on the stamp channel. The date owed for each accepted
// count is typed in or comes from a behavioural civil-date calculation in the
// bench; results leaving on the calendar channel are checked field by field, in
// order. A short directed table (zero, epoch, top of range, leap days,
// century and 2038 wrap points) runs first. A randomised run follows, in phases
// with and without idle cycles on either side, including one long stall on
// the result side so that the pipe fills up and throttles its input.
// ----------------------------------------------------------------------------
module tb_unix_seconds_to_calendar_date;
	import usc_pkg::*;

	localparam int          DIR_ROWS    = 24;
	localparam int          RAND_ITEMS  = 1000;
	localparam int          MAX_IDLE    = 14;
	localparam int          HOLD_CYCLES = 6 * NSTAGE;   // long result-side stall
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int          MAX_PRINTS  = 40;

	// Pacing of the two sides over the run
	typedef enum logic [1:0] {
		PACE_RANDOM,   // both sides idle at random
		PACE_FULL,     // no idle cycles on either side
		PACE_PRESS     // sender flat out, receiver stalls
	} pace_t;

	// One row of the directed table. Where the date is obvious it is typed
	// in; otherwise the civil-date calculation supplies it.
	typedef struct {
		logic [SECS_W-1:0] stamp;
		bit                known;
		cal_t              date;
	} stamp_row_t;

	logic clk;
	logic arst_n;

	usc_in_if  stamp_if ();
	usc_out_if cal_if ();

	unix_seconds_to_calendar_date DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.stamp    (stamp_if),
		.calendar (cal_if)
	);

	cal_t        dates_due [$];   // dates owed by the pipe, oldest first
	pace_t       pace;
	bit          hold_req;
	int unsigned err_cnt;
	int unsigned dates_seen;
	int unsigned cycle_cnt;

	// Directed table. Fields of cal_t: ok, year, month, day, hour, minute,
	// second.
	stamp_row_t directed_rows [DIR_ROWS] = '{
		// zero is rejected: everything cleared
		'{32'd0,          1'b1, '{1'b0, 12'd0,    4'd0, 5'd0,  5'd0, 6'd0,  6'd0}},
		// first second after the epoch
		'{32'd1,          1'b1, '{1'b1, 12'd1970, 4'd1, 5'd1,  5'd0, 6'd0,  6'd1}},
		// top of the 32-bit range
		'{32'hFFFF_FFFF,  1'b1, '{1'b1, 12'd2106, 4'd2, 5'd7,  5'd6, 6'd28, 6'd15}},
		'{32'hFFFF_FFFE,  1'b0, '0},
		// minute, hour and day roll-overs
		'{32'd59,         1'b0, '0},
		'{32'd60,         1'b0, '0},
		'{32'd3599,       1'b0, '0},
		'{32'd3600,       1'b0, '0},
		'{32'd86399,      1'b0, '0},
		'{32'd86400,      1'b0, '0},
		// first new year's eve and day
		'{32'd31535999,   1'b0, '0},
		'{32'd31536000,   1'b0, '0},
		// 1972-02-29, a plain leap day
		'{32'd68169600,   1'b0, '0},
		'{32'd68255999,   1'b0, '0},
		// turn of the millennium, then 2000-02-29 (400-year leap)
		'{32'd946684799,  1'b0, '0},
		'{32'd946684800,  1'b0, '0},
		'{32'd951782400,  1'b0, '0},
		'{32'd951868800,  1'b0, '0},
		// signed 32-bit wrap point
		'{32'd2147483647, 1'b0, '0},
		'{32'd2147483648, 1'b0, '0},
		// 2100 is not a leap year: Feb 28 runs straight into Mar 1
		'{32'd4107542399, 1'b0, '0},
		'{32'd4107542400, 1'b0, '0},
		// alternating bit patterns
		'{32'h5555_5555,  1'b0, '0},
		'{32'hAAAA_AAAA,  1'b0, '0}
	};

	// ------------------------------------------------------------------------
	// Civil date from a seconds count. Time of day by plain division; the day
	// count goes through a Julian-day chain in which Jan and Feb are months
	// 14 and 15 of the previous year and are folded back at the end.
	// ------------------------------------------------------------------------
	function automatic cal_t civil_from_stamp(input logic [SECS_W-1:0] stamp);
		longint unsigned secs, days, cent, jdn, yr, doy, mo, dom;
		cal_t            date;
		date = '0;
		if (stamp == '0)
			return date;
		secs        = stamp;
		date.second = SEC_W'(secs % 60);
		secs        = secs / 60;
		date.minute = MIN_W'(secs % 60);
		secs        = secs / 60;
		date.hour   = HOUR_W'(secs % 24);
		days        = secs / 24;
		// Gregorian century correction
		cent = (4 * days + 102032) / 146097 + 15;
		jdn  = days + 2442113 + cent - cent / 4;
		// year of the chain, day within it, then month and day of month
		yr  = (20 * jdn - 2442) / 7305;
		doy = jdn - 365 * yr - yr / 4;
		mo  = doy * 1000 / 30601;
		dom = doy - mo * 30 - mo * 601 / 1000;
		if (mo <= 13) begin
			yr = yr - 4716;
			mo = mo - 1;
		end else begin
			yr = yr - 4715;
			mo = mo - 13;
		end
		date.ok    = 1'b1;
		date.year  = YEAR_W'(yr);
		date.month = MONTH_W'(mo);
		date.day   = DAY_W'(dom);
		return date;
	endfunction

	task automatic report_mismatch(input string msg);
		err_cnt++;
		if (err_cnt <= MAX_PRINTS)
			$display("ERROR cycle %0d, date %0d: %s", cycle_cnt, dates_seen, msg);
	endtask

	task automatic compare_date(input cal_t got, input cal_t want);
		if (got.ok !== want.ok)
			report_mismatch($sformatf("ok %0d, want %0d", got.ok, want.ok));
		if (got.year !== want.year)
			report_mismatch($sformatf("year %0d, want %0d", got.year, want.year));
		if (got.month !== want.month)
			report_mismatch($sformatf("month %0d, want %0d", got.month, want.month));
		if (got.day !== want.day)
			report_mismatch($sformatf("day %0d, want %0d", got.day, want.day));
		if (got.hour !== want.hour)
			report_mismatch($sformatf("hour %0d, want %0d", got.hour, want.hour));
		if (got.minute !== want.minute)
			report_mismatch($sformatf("minute %0d, want %0d", got.minute, want.minute));
		if (got.second !== want.second)
			report_mismatch($sformatf("second %0d, want %0d", got.second, want.second));
	endtask

	// Offer one count and hold it until the transfer; the owed date is queued
	// at the transfer edge. Entered at a clock edge, with valid possibly still
	// high from the previous transfer: it is either kept high or lowered
	// once, never both in the same step.
	task automatic send_stamp(input logic [SECS_W-1:0] stamp, input bit known,
		input cal_t known_date);
		int gap;
		gap = (pace == PACE_RANDOM) ? $urandom_range(0, MAX_IDLE) : 0;
		if (gap > 0) begin
			stamp_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		stamp_if.valid        <= 1'b1;
		stamp_if.unix_seconds <= stamp;
		do @(posedge clk); while (!stamp_if.ready);
		dates_due.push_back(known ? known_date : civil_from_stamp(stamp));
	endtask

	// Clock, period 2
	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Cycle count and run limit
	initial begin : watchdog
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("tb_unix_seconds_to_calendar_date: FAIL");
		$finish;
	end

	// Result side: outside full pace, ready drops for a drawn number of
	// cycles before each transfer. A pending hold request turns one of those
	// gaps into a long stall so the pipe backs up all the way to its input.
	initial begin : calendar_sink
		int stall;
		cal_if.ready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				stall    = HOLD_CYCLES;
			end else if (pace == PACE_FULL) begin
				stall = 0;
			end else begin
				stall = $urandom_range(0, MAX_IDLE);
			end
			if (stall > 0) begin
				cal_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			cal_if.ready <= 1'b1;
			do @(posedge clk); while (!(cal_if.valid && cal_if.ready));
		end
	end

	// Result check at every transfer on the calendar side
	initial begin : calendar_check
		cal_t got;
		forever begin
			@(posedge clk);
			if (arst_n && cal_if.valid && cal_if.ready) begin
				got = '{cal_if.ok, cal_if.year, cal_if.month, cal_if.day,
					cal_if.hour, cal_if.minute, cal_if.second};
				if (dates_due.size() == 0)
					report_mismatch("date with nothing owed");
				else
					compare_date(got, dates_due.pop_front());
				dates_seen++;
			end
		end
	end

	// Reset, stimulus, drain and verdict
	initial begin : stimulus
		logic [SECS_W-1:0] stamp;
		int unsigned       day_no;
		err_cnt               = 0;
		dates_seen            = 0;
		hold_req              = 1'b0;
		pace                  = PACE_RANDOM;
		arst_n                = 1'b0;
		stamp_if.valid        = 1'b0;
		stamp_if.unix_seconds = '0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		foreach (directed_rows[r])
			send_stamp(directed_rows[r].stamp, directed_rows[r].known,
				directed_rows[r].date);

		// Random run in four phases
		for (int i = 0; i < RAND_ITEMS; i++) begin
			case (i)
				RAND_ITEMS / 4:     pace = PACE_FULL;
				RAND_ITEMS / 2: begin
					pace     = PACE_PRESS;
					hold_req = 1'b1;
				end
				3 * RAND_ITEMS / 4: pace = PACE_RANDOM;
				default: ;
			endcase
			// Last whole day that fits in 32 bits is 49709
			day_no = $urandom_range(0, 49709);
			case ($urandom_range(0, 99)) inside
				[0:39]:  stamp = $urandom;
				[40:69]: begin
					// just either side of midnight
					stamp = SECS_W'(day_no) * SECS_W'(86400);
					case ($urandom_range(0, 3))
						0:       stamp = stamp + 1;
						1:       stamp = stamp + 86399;
						2:       stamp = stamp + 86340 + $urandom_range(0, 59);
						default: ;
					endcase
				end
				[70:79]: stamp = $urandom_range(0, 100000);
				[80:89]: stamp = $urandom_range(32'hFFFF_FFFF - 100000, 32'hFFFF_FFFF);
				[90:97]: stamp = SECS_W'(day_no) * SECS_W'(86400) + $urandom_range(0, 86399);
				default: stamp = '0;
			endcase
			send_stamp(stamp, 1'b0, '0);
		end
		stamp_if.valid <= 1'b0;

		// Drain, then watch for anything stray before the verdict
		while (dates_due.size() != 0)
			@(posedge clk);
		repeat (2 * NSTAGE) @(posedge clk);

		if (err_cnt == 0)
			$display("tb_unix_seconds_to_calendar_date: PASS");
		else
			$display("tb_unix_seconds_to_calendar_date: FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/usc_pkg.sv
hw/rtl/usc_in_if.sv
hw/rtl/usc_out_if.sv
hw/rtl/usc_pipe_ctrl.sv
hw/rtl/usc_tod.sv
hw/rtl/usc_date.sv
hw/rtl/unix_seconds_to_calendar_date.sv
tb/tb_unix_seconds_to_calendar_date.sv
